// ===== rtl/fragment_reassembler_macros.svh =====
// Assertion macros of the fragment reassembler RTL.
`ifndef FRAGMENT_REASSEMBLER_MACROS_SVH
`define FRAGMENT_REASSEMBLER_MACROS_SVH

// Same-cycle implication, checked on i_clk and disabled while i_rst_n is low.
`define FR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk and disabled while i_rst_n is low.
`define FR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fr_pkg.sv =====
// Package with the types and constants of the fragment reassembler.
`default_nettype none

package fr_pkg;

    // Limits of the message buffer and the fragment count.
    localparam int MAX_FRAG  = 16;
    localparam int BUF_BYTES = 256;
    localparam int BUF_AW    = $clog2(BUF_BYTES);
    localparam int LEN_W     = BUF_AW + 1;

    // Item operation codes.
    typedef enum logic [1:0] {
        OP_HEADER = 2'd0,
        OP_BYTE   = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    // Status codes reported on a status result.
    typedef enum logic [2:0] {
        ST_INCOMPLETE   = 3'd0,
        ST_COMPLETE     = 3'd1,
        ST_INCONSISTENT = 3'd2,
        ST_OUT_OF_ORDER = 3'd3,
        ST_OVERFLOW     = 3'd4
    } t_status;

    // One accepted input item.
    typedef struct packed {
        t_op         op;
        logic [15:0] seq_id;
        logic [7:0]  frag_idx;
        logic [7:0]  frag_cnt;
        logic [7:0]  pay_len;
        logic [7:0]  data_byte;
        logic [7:0]  read_address;
    } t_item;

    // Result produced by the control logic for the output register.
    typedef struct packed {
        logic        valid;
        logic        is_read;
        t_status     status;
        logic [15:0] completed_id;
        logic [8:0]  total_length;
        logic        addr_ok;
    } t_result;

    // Buffer write and read request.
    typedef struct packed {
        logic              we;
        logic [BUF_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [BUF_AW-1:0] raddr;
    } t_ram_req;

endpackage

`default_nettype wire

// ===== rtl/fr_in_if.sv =====
// Input channel interface of the fragment reassembler.
`default_nettype none

interface fr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [15:0] seq_id;
    logic [7:0]  frag_idx;
    logic [7:0]  frag_cnt;
    logic [7:0]  pay_len;
    logic [7:0]  data_byte;
    logic [7:0]  read_address;

    modport source (
        output valid, op, seq_id, frag_idx, frag_cnt,
               pay_len, data_byte, read_address,
        input  ready
    );
    modport sink (
        input  valid, op, seq_id, frag_idx, frag_cnt,
               pay_len, data_byte, read_address,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/fr_out_if.sv =====
// Result channel interface of the fragment reassembler.
`default_nettype none

interface fr_out_if;
    logic        valid;
    logic        ready;
    logic        is_read_data;
    logic [2:0]  status;
    logic [15:0] completed_id;
    logic [8:0]  total_length;
    logic [7:0]  read_data;

    modport source (
        output valid, is_read_data, status, completed_id, total_length, read_data,
        input  ready
    );
    modport sink (
        input  valid, is_read_data, status, completed_id, total_length, read_data,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/fr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/fr_ctrl.sv =====
// Assembly state and per-item decision logic of the fragment reassembler.
`default_nettype none

module fr_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire fr_pkg::t_item    i_item,
    output fr_pkg::t_result       o_res,
    output fr_pkg::t_ram_req      o_ram
);
    import fr_pkg::*;

    // Assembly state.
    logic             r_asm, n_asm;
    logic [15:0]      r_cur, n_cur;
    logic [7:0]       r_exp, n_exp;
    logic [7:0]       r_nidx, n_nidx;
    logic [LEN_W-1:0] r_alen, n_alen;
    logic [15:0]      r_last, n_last;
    logic [7:0]       r_brem, n_brem;
    logic             r_pcomp, n_pcomp;
    logic             r_pacc, n_pacc;

    // State as a header sees it, after cancelling a fragment still in progress.
    logic             c_asm;
    logic [15:0]      c_cur;
    logic [7:0]       c_exp;
    logic [7:0]       c_nidx;
    logic [LEN_W-1:0] c_alen;

    // Header checks.
    logic             h_cancel_clr;
    logic             h_bad_cnt;
    logic             h_newseq;
    logic [LEN_W-1:0] h_alen;
    logic [LEN_W:0]   h_sum;
    logic [7:0]       h_idx1;
    logic             h_comp;
    logic             h_fail;
    t_status          h_fail_st;
    logic             b_last;

    // Cancel a pending fragment: an accepted one also drops the assembly.
    assign h_cancel_clr = (r_brem != 8'd0) && r_pacc;
    assign c_asm  = h_cancel_clr ? 1'b0 : r_asm;
    assign c_cur  = h_cancel_clr ? 16'd0 : r_cur;
    assign c_exp  = h_cancel_clr ? 8'd0 : r_exp;
    assign c_nidx = h_cancel_clr ? 8'd0 : r_nidx;
    assign c_alen = h_cancel_clr ? '0 : r_alen;

    // Header consistency, ordering and room checks, in priority order.
    assign h_bad_cnt = (i_item.frag_cnt == 8'd0)
                    || (i_item.frag_cnt > 8'(MAX_FRAG))
                    || (i_item.frag_idx >= i_item.frag_cnt);
    assign h_newseq  = !c_asm || (i_item.seq_id != c_cur);
    assign h_alen    = h_newseq ? '0 : c_alen;
    assign h_sum     = {1'b0, h_alen} + (LEN_W + 1)'(i_item.pay_len);
    assign h_idx1    = 8'(i_item.frag_idx + 8'd1);
    assign h_comp    = (h_idx1 == i_item.frag_cnt);
    assign b_last    = (r_brem == 8'd1);

    always_comb begin
        h_fail    = 1'b1;
        h_fail_st = ST_INCONSISTENT;
        if (h_bad_cnt) begin
            h_fail_st = ST_INCONSISTENT;
        end else if (h_newseq && (i_item.frag_idx != 8'd0)) begin
            h_fail_st = ST_OUT_OF_ORDER;
        end else if (!h_newseq && (i_item.frag_cnt != c_exp)) begin
            h_fail_st = ST_INCONSISTENT;
        end else if (!h_newseq && (i_item.frag_idx != c_nidx)) begin
            h_fail_st = ST_OUT_OF_ORDER;
        end else if (h_sum > (LEN_W + 1)'(BUF_BYTES)) begin
            h_fail_st = ST_OVERFLOW;
        end else begin
            h_fail = 1'b0;
        end
    end

    // Next state, buffer request and result for the accepted item.
    always_comb begin
        n_asm   = r_asm;
        n_cur   = r_cur;
        n_exp   = r_exp;
        n_nidx  = r_nidx;
        n_alen  = r_alen;
        n_last  = r_last;
        n_brem  = r_brem;
        n_pcomp = r_pcomp;
        n_pacc  = r_pacc;
        o_ram   = '0;
        o_res   = '0;
        o_ram.waddr = r_alen[BUF_AW-1:0];
        o_ram.wdata = i_item.data_byte;
        o_ram.raddr = BUF_AW'(i_item.read_address);
        if (i_accept) begin
            case (i_item.op)
                OP_HEADER: begin
                    o_res.valid = 1'b1;
                    if (h_fail) begin
                        n_asm  = 1'b0;
                        n_cur  = 16'd0;
                        n_exp  = 8'd0;
                        n_nidx = 8'd0;
                        n_alen = '0;
                        n_pacc = 1'b0;
                        n_brem = i_item.pay_len;
                        o_res.status = h_fail_st;
                    end else begin
                        n_asm   = 1'b1;
                        n_cur   = i_item.seq_id;
                        n_exp   = i_item.frag_cnt;
                        n_nidx  = h_idx1;
                        n_alen  = h_alen;
                        n_pcomp = h_comp;
                        n_brem  = i_item.pay_len;
                        n_pacc  = 1'b1;
                        o_res.status = h_comp ? ST_COMPLETE : ST_INCOMPLETE;
                        // An empty fragment reports at once.
                        if (i_item.pay_len == 8'd0) begin
                            n_pacc = 1'b0;
                            if (h_comp) begin
                                n_last = i_item.seq_id;
                                n_asm  = 1'b0;
                            end
                        end else begin
                            o_res.valid = 1'b0;
                        end
                    end
                end
                OP_BYTE: begin
                    if (r_brem != 8'd0) begin
                        n_brem = r_brem - 8'd1;
                        if (r_pacc) begin
                            if (r_alen < LEN_W'(BUF_BYTES)) begin
                                o_ram.we = 1'b1;
                                n_alen   = r_alen + LEN_W'(1);
                            end
                            // The fragment's last byte reports its status.
                            if (b_last) begin
                                o_res.valid  = 1'b1;
                                o_res.status = r_pcomp ? ST_COMPLETE : ST_INCOMPLETE;
                                n_pacc = 1'b0;
                                if (r_pcomp) begin
                                    n_last = r_cur;
                                    n_asm  = 1'b0;
                                end
                            end
                        end
                    end
                end
                OP_READ: begin
                    o_ram.re      = 1'b1;
                    o_res.valid   = 1'b1;
                    o_res.is_read = 1'b1;
                    o_res.status  = ST_INCOMPLETE;
                    o_res.addr_ok = (LEN_W'(i_item.read_address) < r_alen);
                end
                default: begin
                end
            endcase
        end
        o_res.completed_id = n_last;
        o_res.total_length = 9'(n_alen);
    end

    // Control state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_asm   <= 1'b0;
            r_cur   <= 16'd0;
            r_exp   <= 8'd0;
            r_nidx  <= 8'd0;
            r_alen  <= '0;
            r_last  <= 16'd0;
            r_brem  <= 8'd0;
            r_pcomp <= 1'b0;
            r_pacc  <= 1'b0;
        end else begin
            r_asm   <= n_asm;
            r_cur   <= n_cur;
            r_exp   <= n_exp;
            r_nidx  <= n_nidx;
            r_alen  <= n_alen;
            r_last  <= n_last;
            r_brem  <= n_brem;
            r_pcomp <= n_pcomp;
            r_pacc  <= n_pacc;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/fragment_reassembler.sv =====
// Top level of the fragment reassembler: control, buffer RAM and result register.
//
// The block takes one item per clock cycle while the output register can take a
// result, headers, payload bytes and reads alike, and a result appears on the
// output channel in the cycle after the item that causes it. The figure is set by
// the single write port and the single registered read port of the message buffer
// RAM, which each item touches at most once. The output register decouples the
// two channels: a new item is taken whenever the register is empty or its result
// is being taken in the same cycle. The buffer needs no clearing after reset, since
// reads at or above the assembled length return zero.
`default_nettype none

`include "fragment_reassembler_macros.svh"

module fragment_reassembler (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fr_in_if.sink     i_frag,
    fr_out_if.source  o_res
);
    import fr_pkg::*;

    t_item    s_item;
    t_result  s_res;
    t_ram_req s_ram;
    logic     s_accept;
    logic     s_ready;
    logic [7:0] s_rdata;

    // Output register.
    logic        r_valid, n_valid;
    logic        r_is_read;
    t_status     r_status;
    logic [15:0] r_cid;
    logic [8:0]  r_tlen;
    logic        r_addr_ok;

    // Input handshake: free output slot or one being emptied.
    assign s_ready      = !r_valid || o_res.ready;
    assign i_frag.ready = s_ready;
    assign s_accept     = i_frag.valid && s_ready;

    assign s_item.op           = t_op'(i_frag.op);
    assign s_item.seq_id       = i_frag.seq_id;
    assign s_item.frag_idx     = i_frag.frag_idx;
    assign s_item.frag_cnt     = i_frag.frag_cnt;
    assign s_item.pay_len      = i_frag.pay_len;
    assign s_item.data_byte    = i_frag.data_byte;
    assign s_item.read_address = i_frag.read_address;

    fr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (s_accept),
        .i_item   (s_item),
        .o_res    (s_res),
        .o_ram    (s_ram)
    );

    fr_ram #(
        .WIDTH (8),
        .DEPTH (BUF_BYTES)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (s_ram.we),
        .i_waddr (s_ram.waddr),
        .i_wdata (s_ram.wdata),
        .i_re    (s_ram.re),
        .i_raddr (s_ram.raddr),
        .o_rdata (s_rdata)
    );

    // Result valid: loaded on accept, cleared once taken.
    always_comb begin
        n_valid = r_valid;
        if (s_ready) begin
            n_valid = s_accept && s_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Result payload, loaded with each accepted item.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_is_read <= s_res.is_read;
            r_status  <= s_res.status;
            r_cid     <= s_res.completed_id;
            r_tlen    <= s_res.total_length;
            r_addr_ok <= s_res.addr_ok;
        end
    end

    // Read data comes straight from the registered RAM output.
    assign o_res.valid        = r_valid;
    assign o_res.is_read_data = r_is_read;
    assign o_res.status       = r_status;
    assign o_res.completed_id = r_cid;
    assign o_res.total_length = r_tlen;
    assign o_res.read_data    = (r_is_read && r_addr_ok) ? s_rdata : 8'd0;

    // Checks on the result path.
    `FR_ASSERT_IMP(a_ready_when_empty, !r_valid, i_frag.ready, "input stalled with empty output")
    `FR_ASSERT_IMP(a_error_clears_len,
        r_valid && !r_is_read && (r_status == ST_INCONSISTENT || r_status == ST_OUT_OF_ORDER
            || r_status == ST_OVERFLOW),
        r_tlen == 9'd0, "error result with nonzero assembled length")
    `FR_ASSERT_IMP(a_len_bound, r_valid, r_tlen <= 9'(BUF_BYTES),
        "assembled length beyond buffer size")
    `FR_ASSERT_NXT(a_read_loads, s_accept && s_item.op == OP_READ,
        r_valid && r_is_read, "read item gave no read result")

endmodule

`default_nettype wire

// ===== tb/fr_result_checker.sv =====
// Result checker of the fragment reassembler: predicts each result and compares it.
module fr_result_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    fr_in_if     i_frag,
    fr_out_if    o_res,
    output int   o_mismatches,
    output int   o_outstanding
);
    import fr_pkg::*;

    // One predicted result, laid out like the result channel.
    typedef struct packed {
        logic        is_read;
        t_status     status;
        logic [15:0] completed_id;
        logic [8:0]  total_length;
        logic [7:0]  read_data;
    } t_outcome;

    // Predicted state of the reassembly.
    logic        assembling;
    logic [15:0] cur_id;
    logic [7:0]  frag_total;
    logic [7:0]  next_frag;
    logic [8:0]  asm_len;
    logic [7:0]  msg_bytes [BUF_BYTES];
    logic [15:0] done_id;
    logic [7:0]  bytes_due;
    t_status     held_status;
    logic        held_accept;
    t_outcome    outcome_q [$];
    int          fail_count = 0;

    // Queue a result; it carries the state as it stands after the item.
    task automatic post(logic is_read, t_status st, logic [7:0] data);
        outcome_q.push_back('{is_read, st, done_id, asm_len, data});
    endtask

    task automatic drop_assembly();
        assembling = 1'b0;
        cur_id     = '0;
        frag_total = '0;
        next_frag  = '0;
        asm_len    = '0;
    endtask

    // An error clears the assembly and the payload that follows is discarded.
    task automatic reject(t_status st, logic [7:0] len);
        drop_assembly();
        held_accept = 1'b0;
        bytes_due   = len;
        post(1'b0, st, 8'd0);
    endtask

    // Report an accepted fragment once its payload is all in.
    task automatic close_fragment();
        if (held_status == ST_COMPLETE) begin
            done_id    = cur_id;
            assembling = 1'b0;
        end
        held_accept = 1'b0;
        post(1'b0, held_status, 8'd0);
    endtask

    // Last check on a header that passed the ordering checks: buffer room.
    task automatic open_fragment(logic [7:0] idx, logic [7:0] len);
        if (int'(asm_len) + int'(len) > BUF_BYTES) begin
            reject(ST_OVERFLOW, len);
        end else begin
            next_frag   = idx + 8'd1;
            held_status = (next_frag == frag_total) ? ST_COMPLETE : ST_INCOMPLETE;
            held_accept = 1'b1;
            bytes_due   = len;
            if (len == 8'd0) close_fragment();
        end
    endtask

    task automatic take_item(t_item it);
        case (it.op)
            OP_HEADER: begin
                // A header while bytes are still due cancels that fragment.
                if (bytes_due != 8'd0) begin
                    if (held_accept) drop_assembly();
                    held_accept = 1'b0;
                    bytes_due   = 8'd0;
                end
                if (it.frag_cnt == 8'd0 || it.frag_cnt > 8'(MAX_FRAG) ||
                    it.frag_idx >= it.frag_cnt) begin
                    reject(ST_INCONSISTENT, it.pay_len);
                end else if (!assembling || it.seq_id != cur_id) begin
                    if (it.frag_idx != 8'd0) begin
                        reject(ST_OUT_OF_ORDER, it.pay_len);
                    end else begin
                        assembling = 1'b1;
                        cur_id     = it.seq_id;
                        frag_total = it.frag_cnt;
                        next_frag  = 8'd0;
                        asm_len    = '0;
                        open_fragment(it.frag_idx, it.pay_len);
                    end
                end else if (it.frag_cnt != frag_total) begin
                    reject(ST_INCONSISTENT, it.pay_len);
                end else if (it.frag_idx != next_frag) begin
                    reject(ST_OUT_OF_ORDER, it.pay_len);
                end else begin
                    open_fragment(it.frag_idx, it.pay_len);
                end
            end
            OP_BYTE: begin
                // Bytes with nothing due are dropped; rejected payload is counted off.
                if (bytes_due != 8'd0) begin
                    bytes_due = bytes_due - 8'd1;
                    if (held_accept) begin
                        if (asm_len < 9'(BUF_BYTES)) begin
                            msg_bytes[asm_len[7:0]] = it.data_byte;
                            asm_len = asm_len + 9'd1;
                        end
                        if (bytes_due == 8'd0) close_fragment();
                    end
                end
            end
            OP_READ: begin
                // Positions past the assembled length read as zero.
                if ({1'b0, it.read_address} < asm_len)
                    post(1'b1, ST_INCOMPLETE, msg_bytes[it.read_address]);
                else
                    post(1'b1, ST_INCOMPLETE, 8'd0);
            end
            default: ;
        endcase
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Compare results first, then predict from the item taken at the same edge.
    always @(posedge i_clk) begin : watch
        t_outcome want;
        t_item    it;
        if (!i_rst_n) begin
            drop_assembly();
            done_id     = '0;
            bytes_due   = '0;
            held_status = ST_INCOMPLETE;
            held_accept = 1'b0;
            outcome_q.delete();
        end else begin
            if (o_res.valid && o_res.ready) begin
                if (outcome_q.size() == 0) begin
                    $error("result arrived with no item outstanding");
                    fail_count++;
                end else begin
                    want = outcome_q.pop_front();
                    check_field("is_read_data", 32'(want.is_read), 32'(o_res.is_read_data));
                    check_field("status", 32'(want.status), 32'(o_res.status));
                    check_field("completed_id", 32'(want.completed_id),
                                32'(o_res.completed_id));
                    check_field("total_length", 32'(want.total_length),
                                32'(o_res.total_length));
                    check_field("read_data", 32'(want.read_data), 32'(o_res.read_data));
                end
            end
            if (i_frag.valid && i_frag.ready) begin
                it.op           = t_op'(i_frag.op);
                it.seq_id       = i_frag.seq_id;
                it.frag_idx     = i_frag.frag_idx;
                it.frag_cnt     = i_frag.frag_cnt;
                it.pay_len      = i_frag.pay_len;
                it.data_byte    = i_frag.data_byte;
                it.read_address = i_frag.read_address;
                take_item(it);
            end
        end
        o_outstanding <= outcome_q.size();
        o_mismatches  <= fail_count;
    end

endmodule

// ===== tb/tb_fragment_reassembler.sv =====
// Testbench top of the fragment reassembler: clock, reset, stimulus and verdict.
module tb_fragment_reassembler;
    import fr_pkg::*;

    localparam int ITEM_TARGET  = 1350;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 16;

    logic clk = 1'b0;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    int   items_sent = 0;
    bit   no_gap = 1'b0;
    bit   hold_req = 1'b0;

    fr_in_if  frag_if ();
    fr_out_if res_if ();

    fragment_reassembler dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_frag  (frag_if),
        .o_res   (res_if)
    );

    fr_result_checker result_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_frag        (frag_if),
        .o_res         (res_if),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always #5 clk = ~clk;

    // Hard stop in case the block hangs.
    initial begin
        #3_000_000;
        $display("** fragment_reassembler: FAILED **");
        $finish;
    end

    // Fields a given operation does not use are random as well.
    function automatic t_item fresh_item(t_op op);
        t_item it;
        it.op           = op;
        it.seq_id       = 16'($urandom);
        it.frag_idx     = 8'($urandom);
        it.frag_cnt     = 8'($urandom);
        it.pay_len      = 8'($urandom);
        it.data_byte    = 8'($urandom);
        it.read_address = 8'($urandom);
        return it;
    endfunction

    // Offer one item after a random gap and hold it until it is taken.
    task automatic send(t_item it, bit counted);
        int gap;
        gap = no_gap ? 0 : int'($urandom_range(0, 11));
        if (gap > 0) begin
            frag_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frag_if.valid        <= 1'b1;
        frag_if.op           <= it.op;
        frag_if.seq_id       <= it.seq_id;
        frag_if.frag_idx     <= it.frag_idx;
        frag_if.frag_cnt     <= it.frag_cnt;
        frag_if.pay_len      <= it.pay_len;
        frag_if.data_byte    <= it.data_byte;
        frag_if.read_address <= it.read_address;
        @(posedge clk);
        while (!frag_if.ready) @(posedge clk);
        if (counted) items_sent++;
    endtask

    task automatic send_header(logic [15:0] id, logic [7:0] idx, logic [7:0] cnt,
                               logic [7:0] len);
        t_item it;
        it = fresh_item(OP_HEADER);
        it.seq_id   = id;
        it.frag_idx = idx;
        it.frag_cnt = cnt;
        it.pay_len  = len;
        send(it, 1'b1);
    endtask

    task automatic send_byte(logic [7:0] data, bit counted);
        t_item it;
        it = fresh_item(OP_BYTE);
        it.data_byte = data;
        send(it, counted);
    endtask

    task automatic send_read(logic [7:0] addr);
        t_item it;
        it = fresh_item(OP_READ);
        it.read_address = addr;
        send(it, 1'b1);
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic wait_idle();
        frag_if.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // One message of numbered fragments with occasional damage and noise mixed in.
    task automatic send_message();
        logic [15:0] id;
        logic [7:0]  idx, cnt;
        int          frags, k, j, len, nb, used, r;
        bit          bulk;
        no_gap = ($urandom_range(0, 5) == 0);
        id     = 16'($urandom);
        bulk   = ($urandom_range(0, 29) == 0);
        if (bulk)
            frags = $urandom_range(2, 3);
        else if ($urandom_range(0, 3) == 0)
            frags = $urandom_range(1, MAX_FRAG);
        else
            frags = $urandom_range(1, 4);
        used = 0;
        for (k = 0; k < frags; k++) begin
            // Noise ahead of the header.
            r = $urandom_range(0, 99);
            if (r < 3)
                send_byte(8'($urandom), 1'b0);
            else if (r < 5)
                send(fresh_item(OP_NONE), 1'b0);
            else if (r < 9)
                send_read(8'($urandom_range(0, used)));
            else if (r < 12)
                send_header(16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));

            // Large payloads are rare except in bulk messages, which may fill or overflow.
            if (bulk)
                len = (k == 1 && $urandom_range(0, 2) == 0) ? 256 - used
                                                            : $urandom_range(60, 255);
            else
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 255)
                                                   : $urandom_range(0, 8);

            // Mostly well formed, sometimes a bad index, count or a switched sequence.
            idx = 8'(k);
            cnt = 8'(frags);
            r = $urandom_range(0, 99);
            if (r < 3)
                idx = 8'($urandom);
            else if (r < 5)
                cnt = 8'($urandom_range(0, MAX_FRAG + 1));
            else if (r < 6)
                id = 16'($urandom);
            send_header(id, idx, cnt, 8'(len));

            // Payload that cannot fit, and now and then other payload, is cut short; the next header cancels it.
            if (used + len > BUF_BYTES || $urandom_range(0, 24) == 0)
                nb = $urandom_range(0, 3);
            else
                nb = len;
            if (nb > len) nb = len;
            used += len;
            for (j = 0; j < nb; j++) begin
                if ($urandom_range(0, 29) == 0) send_read(8'($urandom_range(0, used)));
                send_byte(8'($urandom), 1'b1);
            end
        end

        // Read some of the assembled message back.
        r = $urandom_range(0, 3);
        for (j = 0; j < r; j++)
            send_read(($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                  : 8'($urandom_range(0, used)));
    endtask

    // Result side: random stalls, steady stretches and one long hold-off.
    initial begin : drain_results
        int stall;
        int mode_left;
        bit steady;
        res_if.ready <= 1'b0;
        mode_left = 0;
        steady    = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (mode_left == 0) begin
                steady    = ($urandom_range(0, 3) == 0);
                mode_left = $urandom_range(20, 60);
            end
            mode_left--;
            if (hold_req) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            stall = steady ? 0 : int'($urandom_range(0, 11));
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            @(posedge clk);
            while (!res_if.valid) @(posedge clk);
        end
    end

    // Item side: reset, directed cases, random messages, then the verdict.
    initial begin : stimulus
        int next_pause;
        bit hold_done;
        rst_n                <= 1'b0;
        frag_if.valid        <= 1'b0;
        frag_if.op           <= OP_NONE;
        frag_if.seq_id       <= '0;
        frag_if.frag_idx     <= '0;
        frag_if.frag_cnt     <= '0;
        frag_if.pay_len      <= '0;
        frag_if.data_byte    <= '0;
        frag_if.read_address <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Read of an empty buffer.
        send_read(8'd0);
        // Zero count, then its payload is discarded.
        send_header(16'h0001, 8'd0, 8'd0, 8'd2);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        // Count above the limit, and index not below the count.
        send_header(16'h0002, 8'd0, 8'(MAX_FRAG + 1), 8'd0);
        send_header(16'h0003, 8'd2, 8'd2, 8'd0);
        send_header(16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
        // New sequence that does not start at fragment zero.
        send_header(16'h1234, 8'd1, 8'd4, 8'd0);
        // First fragment accepted, then a stray byte and an unused operation.
        send_header(16'hFFFF, 8'd0, 8'd2, 8'd1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h55, 1'b0);
        send(fresh_item(OP_NONE), 1'b0);
        // Continuing sequence whose count changed.
        send_header(16'hFFFF, 8'd1, 8'd3, 8'd0);
        // Single empty fragment completes at once.
        send_header(16'h0000, 8'd0, 8'd1, 8'd0);
        // Header in the middle of a payload cancels the assembly.
        send_header(16'h0007, 8'd0, 8'd2, 8'd2);
        send_byte(8'hA5, 1'b1);
        send_header(16'h0007, 8'd1, 8'd2, 8'd0);
        // Complete message, read inside and beyond its length.
        send_header(16'h0009, 8'd0, 8'd1, 8'd3);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h5A, 1'b1);
        send_read(8'd2);
        send_read(8'd3);
        send_read(8'hFF);
        // Continuing sequence that skips an index.
        send_header(16'h0014, 8'd0, 8'd3, 8'd0);
        send_header(16'h0014, 8'd2, 8'd3, 8'd0);
        wait_idle();

        // Random messages with one long result stall and a few full drains.
        next_pause = 300;
        hold_done  = 1'b0;
        while (items_sent < ITEM_TARGET) begin
            send_message();
            if (!hold_done && items_sent >= 500) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (items_sent >= next_pause) begin
                wait_idle();
                next_pause += 400;
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("** fragment_reassembler: PASSED **");
        else
            $display("** fragment_reassembler: FAILED **");
        $finish;
    end

endmodule
